[rtl/i2c_eeprom_byte_master_core_assert.svh]
// Assertion macros used by the checker file of the EEPROM byte master.
`ifndef I2C_EEPROM_BYTE_MASTER_CORE_ASSERT_SVH
`define I2C_EEPROM_BYTE_MASTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while rst is high.
`define EBM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("EEPROM byte master assertion failed");

// Next-cycle implication, disabled while rst is high.
`define EBM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("EEPROM byte master assertion failed");

`endif

[rtl/i2c_ebm_pkg.sv]
// Types, constants and the command sequence table of the EEPROM byte master.
package i2c_ebm_pkg;

   typedef struct packed {
      logic       request;
      logic       cmd;
      logic [7:0] mem_addr;
      logic [7:0] write_data;
      logic       sda_in;
   } req_item_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_release;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic       ack_missing;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0] phase_ticks;
      logic [6:0] device_address;
      logic [7:0] ack_wait_limit;
      logic [7:0] nack_wait_limit;
   } cfg_type;

   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [1:0] REG_PHASE_TICKS     = 2'd0;
   localparam logic [1:0] REG_DEVICE_ADDRESS  = 2'd1;
   localparam logic [1:0] REG_ACK_WAIT_LIMIT  = 2'd2;
   localparam logic [1:0] REG_NACK_WAIT_LIMIT = 2'd3;

   localparam logic [7:0] PHASE_TICKS_RST     = 8'd7;
   localparam logic [6:0] DEVICE_ADDRESS_RST  = 7'd80;
   localparam logic [7:0] ACK_WAIT_LIMIT_RST  = 8'd200;
   localparam logic [7:0] NACK_WAIT_LIMIT_RST = 8'd100;

   localparam logic [3:0] SEQ_LEN = 4'd12;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   typedef enum logic [3:0] {
      OP_END,
      OP_START,
      OP_DEVW,
      OP_ADDR,
      OP_DATA,
      OP_DEVR,
      OP_RESP,
      OP_RBYTE,
      OP_NOACK,
      OP_STOP
   } op_type;

   function automatic op_type seq_op(input logic cmd, input logic [3:0] step);
      op_type op;
      case (step)
         4'd0: op = OP_START;
         4'd1: op = OP_DEVW;
         4'd2: op = OP_RESP;
         4'd3: op = OP_ADDR;
         4'd4: op = OP_RESP;
         4'd5: op = (cmd == CMD_READ) ? OP_START : OP_DATA;
         4'd6: op = (cmd == CMD_READ) ? OP_DEVR  : OP_RESP;
         4'd7: op = (cmd == CMD_READ) ? OP_RESP  : OP_STOP;
         4'd8: op = (cmd == CMD_READ) ? OP_RBYTE : OP_END;
         4'd9: op = (cmd == CMD_READ) ? OP_NOACK : OP_END;
         4'd10: op = (cmd == CMD_READ) ? OP_STOP : OP_END;
         default: op = OP_END;
      endcase
      return op;
   endfunction

endpackage

[rtl/i2c_ebm_csr.sv]
// Configuration register file of the EEPROM byte master with its APB-style port.
module i2c_ebm_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [i2c_ebm_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [i2c_ebm_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [i2c_ebm_pkg::CSR_DATA_W-1:0] prdata,
   output logic                               pready,
   output i2c_ebm_pkg::cfg_type               cfg
);
   import i2c_ebm_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_sel;

   assign pready  = 1'b1;
   assign reg_sel = paddr[3:2];
   assign wr_en   = psel & penable & pwrite & pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_PHASE_TICKS:     cfg_in.phase_ticks     = pwdata[7:0];
            REG_DEVICE_ADDRESS:  cfg_in.device_address  = pwdata[6:0];
            REG_ACK_WAIT_LIMIT:  cfg_in.ack_wait_limit  = pwdata[7:0];
            REG_NACK_WAIT_LIMIT: cfg_in.nack_wait_limit = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_PHASE_TICKS:     prdata = {24'd0, cfg_ff.phase_ticks};
         REG_DEVICE_ADDRESS:  prdata = {25'd0, cfg_ff.device_address};
         REG_ACK_WAIT_LIMIT:  prdata = {24'd0, cfg_ff.ack_wait_limit};
         REG_NACK_WAIT_LIMIT: prdata = {24'd0, cfg_ff.nack_wait_limit};
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_ticks     <= PHASE_TICKS_RST;
         cfg_ff.device_address  <= DEVICE_ADDRESS_RST;
         cfg_ff.ack_wait_limit  <= ACK_WAIT_LIMIT_RST;
         cfg_ff.nack_wait_limit <= NACK_WAIT_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/i2c_ebm_seq.sv]
// Bus sequencer of the EEPROM byte master: advances one tick per step and forms the result.
module i2c_ebm_seq (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step_en,
   input  i2c_ebm_pkg::req_item_type item,
   input  i2c_ebm_pkg::cfg_type      cfg,
   output i2c_ebm_pkg::rsp_item_type result
);
   import i2c_ebm_pkg::*;

   typedef enum logic [4:0] {
      PH_IDLE, PH_S1, PH_S2, PH_S3, PH_W0, PH_WHI, PH_WLO, PH_WREL,
      PH_R1, PH_RW, PH_R2, PH_P1, PH_P2, PH_P3, PH_RD0, PH_RD1,
      PH_RHI, PH_RLO, PH_N1, PH_NW, PH_N2
   } phase_type;

   phase_type  phase_ff, phase_in, enter_ph;
   logic [7:0] tick_ff, tick_in;
   logic [7:0] wait_ff, wait_in;
   logic [2:0] bit_ff, bit_in;
   logic [7:0] shift_ff, shift_in;
   logic       cmd_ff, cmd_in;
   logic [7:0] addr_ff, addr_in;
   logic [7:0] data_ff, data_in;
   logic [7:0] recv_ff, recv_in;
   logic       timeout_ff, timeout_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in;
   logic [3:0] seq_ff, seq_in;
   logic       done;
   logic       go_enter;
   logic       run_op;
   op_type     op;
   logic [7:0] hold;

   assign hold = (cfg.phase_ticks == 8'd0) ? 8'd1 : cfg.phase_ticks;

   always_comb begin
      phase_in   = phase_ff;
      tick_in    = tick_ff;
      wait_in    = wait_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      cmd_in     = cmd_ff;
      addr_in    = addr_ff;
      data_in    = data_ff;
      recv_in    = recv_ff;
      timeout_in = timeout_ff;
      scl_in     = scl_ff;
      sda_in     = sda_ff;
      seq_in     = seq_ff;
      done       = 1'b0;
      go_enter   = 1'b0;
      enter_ph   = PH_IDLE;
      run_op     = 1'b0;
      op         = OP_END;

      if (step_en) begin
         case (phase_ff)
            PH_IDLE: begin
               if (item.request) begin
                  cmd_in     = item.cmd;
                  addr_in    = item.mem_addr;
                  data_in    = item.write_data;
                  timeout_in = 1'b0;
                  seq_in     = 4'd0;
                  run_op     = 1'b1;
               end
            end
            PH_RW: begin
               if (item.sda_in && (wait_ff < cfg.ack_wait_limit)) begin
                  wait_in = wait_ff + 8'd1;
               end else begin
                  if (item.sda_in) begin
                     timeout_in = 1'b1;
                  end
                  go_enter = 1'b1;
                  enter_ph = PH_R2;
               end
            end
            PH_NW: begin
               if (!item.sda_in && (wait_ff < cfg.nack_wait_limit)) begin
                  wait_in = wait_ff + 8'd1;
               end else begin
                  go_enter = 1'b1;
                  enter_ph = PH_N2;
               end
            end
            default: begin
               if (tick_ff >= hold) begin
                  case (phase_ff)
                     PH_S1: begin go_enter = 1'b1; enter_ph = PH_S2; end
                     PH_S2: begin go_enter = 1'b1; enter_ph = PH_S3; end
                     PH_W0: begin go_enter = 1'b1; enter_ph = PH_WHI; end
                     PH_WHI: begin
                        shift_in = {shift_ff[6:0], 1'b0};
                        go_enter = 1'b1;
                        enter_ph = PH_WLO;
                     end
                     PH_WLO: begin
                        go_enter = 1'b1;
                        if (bit_ff == 3'd7) begin
                           enter_ph = PH_WREL;
                        end else begin
                           bit_in   = bit_ff + 3'd1;
                           enter_ph = PH_WHI;
                        end
                     end
                     PH_R1: begin go_enter = 1'b1; enter_ph = PH_RW; end
                     PH_P1: begin go_enter = 1'b1; enter_ph = PH_P2; end
                     PH_P2: begin go_enter = 1'b1; enter_ph = PH_P3; end
                     PH_RD0: begin go_enter = 1'b1; enter_ph = PH_RD1; end
                     PH_RD1: begin go_enter = 1'b1; enter_ph = PH_RHI; end
                     PH_RHI: begin
                        shift_in = {shift_ff[6:0], item.sda_in};
                        go_enter = 1'b1;
                        enter_ph = PH_RLO;
                     end
                     PH_RLO: begin
                        if (bit_ff == 3'd7) begin
                           recv_in = shift_ff;
                           seq_in  = (seq_ff < SEQ_LEN) ? seq_ff + 4'd1 : seq_ff;
                           run_op  = 1'b1;
                        end else begin
                           bit_in   = bit_ff + 3'd1;
                           go_enter = 1'b1;
                           enter_ph = PH_RHI;
                        end
                     end
                     PH_N1: begin go_enter = 1'b1; enter_ph = PH_NW; end
                     PH_S3, PH_WREL, PH_R2, PH_P3, PH_N2: begin
                        seq_in = (seq_ff < SEQ_LEN) ? seq_ff + 4'd1 : seq_ff;
                        run_op = 1'b1;
                     end
                     default: begin
                        phase_in = PH_IDLE;
                        tick_in  = 8'd0;
                        seq_in   = 4'd0;
                     end
                  endcase
               end else begin
                  tick_in = tick_ff + 8'd1;
               end
            end
         endcase
      end

      if (run_op) begin
         op = seq_op(cmd_in, seq_in);
         case (op)
            OP_START: begin go_enter = 1'b1; enter_ph = PH_S1; end
            OP_DEVW: begin
               shift_in = {cfg.device_address, 1'b0};
               bit_in   = 3'd0;
               go_enter = 1'b1;
               enter_ph = PH_W0;
            end
            OP_DEVR: begin
               shift_in = {cfg.device_address, 1'b1};
               bit_in   = 3'd0;
               go_enter = 1'b1;
               enter_ph = PH_W0;
            end
            OP_ADDR: begin
               shift_in = addr_in;
               bit_in   = 3'd0;
               go_enter = 1'b1;
               enter_ph = PH_W0;
            end
            OP_DATA: begin
               shift_in = data_in;
               bit_in   = 3'd0;
               go_enter = 1'b1;
               enter_ph = PH_W0;
            end
            OP_RESP: begin go_enter = 1'b1; enter_ph = PH_R1; end
            OP_RBYTE: begin
               shift_in = 8'd0;
               bit_in   = 3'd0;
               go_enter = 1'b1;
               enter_ph = PH_RD0;
            end
            OP_NOACK: begin go_enter = 1'b1; enter_ph = PH_N1; end
            OP_STOP: begin go_enter = 1'b1; enter_ph = PH_P1; end
            default: begin
               phase_in = PH_IDLE;
               tick_in  = 8'd0;
               seq_in   = 4'd0;
               done     = 1'b1;
            end
         endcase
      end

      if (go_enter) begin
         phase_in = enter_ph;
         tick_in  = 8'd1;
         wait_in  = 8'd0;
         case (enter_ph)
            PH_S1, PH_R1, PH_P2, PH_RHI, PH_N1: scl_in = 1'b1;
            PH_W0, PH_WLO, PH_R2, PH_RD0, PH_RLO, PH_N2: scl_in = 1'b0;
            PH_S2, PH_WREL, PH_P3, PH_RD1: sda_in = 1'b1;
            PH_S3, PH_P1: sda_in = 1'b0;
            PH_WHI: begin
               sda_in = shift_in[7];
               scl_in = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      result.scl_level   = scl_in;
      result.sda_release = sda_in;
      result.busy_res    = (phase_in != PH_IDLE);
      result.done_res    = done;
      result.read_data   = recv_in;
      result.ack_missing = timeout_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         tick_ff    <= 8'd0;
         wait_ff    <= 8'd0;
         bit_ff     <= 3'd0;
         shift_ff   <= 8'd0;
         cmd_ff     <= 1'b0;
         addr_ff    <= 8'd0;
         data_ff    <= 8'd0;
         recv_ff    <= 8'd0;
         timeout_ff <= 1'b0;
         scl_ff     <= 1'b1;
         sda_ff     <= 1'b1;
         seq_ff     <= 4'd0;
      end else begin
         phase_ff   <= phase_in;
         tick_ff    <= tick_in;
         wait_ff    <= wait_in;
         bit_ff     <= bit_in;
         shift_ff   <= shift_in;
         cmd_ff     <= cmd_in;
         addr_ff    <= addr_in;
         data_ff    <= data_in;
         recv_ff    <= recv_in;
         timeout_ff <= timeout_in;
         scl_ff     <= scl_in;
         sda_ff     <= sda_in;
         seq_ff     <= seq_in;
      end
   end

endmodule

[rtl/i2c_eeprom_byte_master_core.sv]
// Top level of the I2C EEPROM byte master: input register, sequencer and result register.
// Each req transaction carries one bus tick: a start request with command, word
// address and write byte, plus the sampled SDA level. Each tick yields exactly one
// rsp transaction with the SCL and SDA drive levels, busy, a done pulse, the last
// byte read and the ack timeout flag.
// A tick is taken into the input register, advanced through the sequencer when the
// result register is free or being taken, and registered in the result register.
// One tick is accepted every cycle while rsp is not stalled; the sequencer state
// update is the single stage that sets this rate.
// While rsp_stall is high the result register holds its transaction; the input
// register still takes a tick if it is empty, after which req_stall rises until the
// result is taken.
// Reset is synchronous: both registers empty, the bus released with SCL and SDA
// high, the sequencer idle, and the configuration registers back at their defaults
// (phase ticks 7, device 80, ack limit 200, no-ack limit 100). The user must write
// configuration via the APB-style port only while idle; the block does not enforce it.
module i2c_eeprom_byte_master_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  i2c_ebm_pkg::req_item_type          req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output i2c_ebm_pkg::rsp_item_type          rsp_data,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [i2c_ebm_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [i2c_ebm_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [i2c_ebm_pkg::CSR_DATA_W-1:0] prdata,
   output logic                               pready
);
   import i2c_ebm_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_item_type in_data_ff, in_data_in;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_data_ff, out_data_in;
   logic         step_en;
   logic         in_take;
   cfg_type      cfg;
   rsp_item_type step_result;

   i2c_ebm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   i2c_ebm_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (in_data_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   assign step_en   = in_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~step_en;
   assign in_take   = req_valid & ~req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (in_take) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end else if (step_en) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (step_en) begin
         out_valid_in = 1'b1;
         out_data_in  = step_result;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

[rtl/i2c_ebm_checker.sv]
// Port-level checker for the I2C EEPROM byte master and its bind statement.
`include "i2c_eeprom_byte_master_core_assert.svh"

module i2c_ebm_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input i2c_ebm_pkg::rsp_item_type rsp_data
);
   import i2c_ebm_pkg::*;

   // A stalled result transaction stays in place.
   `EBM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // Reset leaves both channels empty and ready.
   `EBM_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid && !req_stall)

   // The done pulse comes on the tick the sequencer returns to idle.
   `EBM_ASSERT_IMPLY(a_done_idle, clock, reset, rsp_valid && rsp_data.done_res, !rsp_data.busy_res)

   // An idle sequencer always leaves the bus released.
   `EBM_ASSERT_IMPLY(a_idle_bus, clock, reset, rsp_valid && !rsp_data.busy_res, rsp_data.scl_level && rsp_data.sda_release)

endmodule

bind i2c_eeprom_byte_master_core i2c_ebm_checker u_ebm_checker (.*);
